// ===== rtl/minhash_pair_similarity_top_assert.svh =====
// Assertion macros shared by the minhash pair similarity RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MINHASH_PAIR_SIMILARITY_TOP_ASSERT_SVH
`define MINHASH_PAIR_SIMILARITY_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MHPS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MHPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mhps_pkg.sv =====
// Shared types and codes of the minhash pair similarity block.
// Depends on nothing; imported by the controller, datapath, top level and testbench.
package mhps_pkg;

    // request codes
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPARE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_COMPARED     = 2'd0;
    localparam logic [1:0] STATUS_SAME_RULE    = 2'd1;
    localparam logic [1:0] STATUS_FILTERED     = 2'd2;
    localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd3;

    // configuration register indexes
    localparam logic CFG_NUM_HASHES = 1'b0;
    localparam logic CFG_NUM_RULES  = 1'b1;

    // configuration reset values
    localparam logic [6:0] NUM_HASHES_RESET = 7'd64;
    localparam logic [8:0] NUM_RULES_RESET  = 9'd0;

    // request beat
    typedef struct packed {
        logic        req_type;
        logic [7:0]  rule_a;
        logic [7:0]  rule_b;
        logic [5:0]  position;
        logic [63:0] hash_value;
        logic        is_constant_rule;
        logic [1:0]  rule_type;
        logic [23:0] head_constant;
    } req_item_t;

    // response beat
    typedef struct packed {
        logic [6:0] match_count;
        logic [1:0] status;
        logic       similar;
    } rsp_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load_write;
        logic attr_read;
        logic check;
        logic scan_issue;
        logic out_load;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_compare;
        logic early_done;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/mhps_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module mhps_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              rd_en_a,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [WIDTH-1:0]  rdata_a,
    input  logic              rd_en_b,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (rd_en_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/mhps_ctrl.sv =====
// Controller state machine of the minhash pair similarity block.
// Depends on mhps_pkg; drives the datapath through ctl_cmd_t.
module mhps_ctrl import mhps_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t stat,
    output ctl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ATTR,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (stat.is_compare) ? S_ATTR : S_LOAD;
                end
            end
            S_LOAD:  state_next = S_IDLE;
            S_ATTR:  state_next = S_CHECK;
            S_CHECK: state_next = (stat.early_done) ? S_DONE : S_SCAN;
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_DONE;
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // commands decoded from state
    always_comb
    begin
        req_ready      = (state_reg == S_IDLE);
        cmd            = '0;
        cmd.capture    = (state_reg == S_IDLE) && req_valid;
        cmd.load_write = (state_reg == S_LOAD);
        cmd.attr_read  = (state_reg == S_ATTR);
        cmd.check      = (state_reg == S_CHECK);
        cmd.scan_issue = (state_reg == S_SCAN);
        cmd.out_load   = (state_reg == S_DONE) && stat.out_free;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/mhps_datapath.sv =====
// Datapath: config registers, signature and attribute stores, match counter.
// Depends on mhps_pkg, mhps_ram and the assertion macro header.
`include "minhash_pair_similarity_top_assert.svh"

module mhps_datapath import mhps_pkg::*; #(
    parameter int MAX_RULES    = 256,
    parameter int MAX_HASHES   = 64,
    parameter int HEAD_ID_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    input  req_item_t  req_item,
    input  logic       cfg_valid,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_item_t  rsp_item,
    input  ctl_cmd_t   cmd,
    output dp_status_t stat
);

    localparam int RULE_W    = $clog2(MAX_RULES);
    localparam int SIG_DEPTH = MAX_RULES * MAX_HASHES;
    localparam int SIG_AW    = $clog2(SIG_DEPTH);
    localparam int BASE_W    = RULE_W + 11;
    localparam int ATTR_W    = 3 + HEAD_ID_BITS;
    localparam logic [12:0] MAX_RULES_W  = 13'(MAX_RULES);
    localparam logic [10:0] MAX_HASHES_W = 11'(MAX_HASHES);

    // configuration
    logic [6:0] num_hashes_reg;
    logic [8:0] num_rules_reg;

    // captured request
    logic              is_compare;
    logic [12:0]       ra_ext;
    logic [12:0]       rb_ext;
    logic [7:0]        ra_reg;
    logic [7:0]        rb_reg;
    logic [RULE_W-1:0] ra_idx_reg;
    logic [RULE_W-1:0] rb_idx_reg;
    logic [BASE_W-1:0] base_a_reg;
    logic [BASE_W-1:0] base_b_reg;
    logic [5:0]        pos_reg;
    logic [63:0]       hash_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic              rule_ok_reg;
    logic              pos_ok_reg;
    logic [31:0]       head_ext;

    // compare state
    logic [1:0] status_reg;
    logic [1:0] status_calc;
    logic [6:0] nh_reg;
    logic [6:0] nh_sat;
    logic [6:0] m_reg;
    logic [6:0] count_reg;
    logic       pend_reg;
    logic [12:0] nr_ext;
    logic [12:0] nr_sat;
    logic        range_bad;
    logic        filtered;

    // store ports
    logic [BASE_W-1:0] load_sum;
    logic [BASE_W-1:0] scan_sum_a;
    logic [BASE_W-1:0] scan_sum_b;
    logic [63:0]       sig_a;
    logic [63:0]       sig_b;
    logic [ATTR_W-1:0] attr_a;
    logic [ATTR_W-1:0] attr_b;

    // output register
    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg <= NUM_HASHES_RESET;
            num_rules_reg  <= NUM_RULES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUM_HASHES: num_hashes_reg <= cfg_data[6:0];
                CFG_NUM_RULES:  num_rules_reg  <= cfg_data;
                default:        num_rules_reg  <= num_rules_reg;
            endcase
        end
    end

    // request decode
    assign is_compare = (req_item.req_type == REQ_COMPARE);
    assign ra_ext     = 13'(req_item.rule_a);
    assign rb_ext     = 13'(req_item.rule_b);
    assign head_ext   = 32'(req_item.head_constant);

    // capture of the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ra_reg      <= req_item.rule_a;
            rb_reg      <= req_item.rule_b;
            ra_idx_reg  <= ra_ext[RULE_W-1:0];
            rb_idx_reg  <= rb_ext[RULE_W-1:0];
            base_a_reg  <= BASE_W'(ra_ext[RULE_W-1:0]) * BASE_W'(MAX_HASHES);
            base_b_reg  <= BASE_W'(rb_ext[RULE_W-1:0]) * BASE_W'(MAX_HASHES);
            pos_reg     <= req_item.position;
            hash_reg    <= req_item.hash_value;
            attr_reg    <= {req_item.is_constant_rule, req_item.rule_type,
                            head_ext[HEAD_ID_BITS-1:0]};
            rule_ok_reg <= (ra_ext < MAX_RULES_W);
            pos_ok_reg  <= (11'(req_item.position) < MAX_HASHES_W);
        end
    end

    // store addresses
    assign load_sum   = base_a_reg + BASE_W'(pos_reg);
    assign scan_sum_a = base_a_reg + BASE_W'(m_reg);
    assign scan_sum_b = base_b_reg + BASE_W'(m_reg);

    // signature store
    mhps_ram #(
        .WIDTH (64),
        .DEPTH (SIG_DEPTH)
    ) u_sig_ram (
        .clk     (clk),
        .we      (cmd.load_write && rule_ok_reg && pos_ok_reg),
        .waddr   (load_sum[SIG_AW-1:0]),
        .wdata   (hash_reg),
        .rd_en_a (cmd.scan_issue),
        .raddr_a (scan_sum_a[SIG_AW-1:0]),
        .rdata_a (sig_a),
        .rd_en_b (cmd.scan_issue),
        .raddr_b (scan_sum_b[SIG_AW-1:0]),
        .rdata_b (sig_b)
    );

    // rule attribute store: constant flag, type, head constant
    mhps_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (MAX_RULES)
    ) u_attr_ram (
        .clk     (clk),
        .we      (cmd.load_write && rule_ok_reg),
        .waddr   (ra_idx_reg),
        .wdata   (attr_reg),
        .rd_en_a (cmd.attr_read),
        .raddr_a (ra_idx_reg),
        .rdata_a (attr_a),
        .rd_en_b (cmd.attr_read),
        .raddr_b (rb_idx_reg),
        .rdata_b (attr_b)
    );

    // pair screening, range first, then same rule, then the constant filter
    always_comb
    begin
        nr_ext    = 13'(num_rules_reg);
        nr_sat    = (nr_ext > MAX_RULES_W) ? MAX_RULES_W : nr_ext;
        range_bad = (13'(ra_reg) >= nr_sat) || (13'(rb_reg) >= nr_sat);
        filtered  = attr_a[ATTR_W-1] && attr_b[ATTR_W-1]
                    && (attr_a[ATTR_W-2:HEAD_ID_BITS] == attr_b[ATTR_W-2:HEAD_ID_BITS])
                    && (attr_a[HEAD_ID_BITS-1:0] != attr_b[HEAD_ID_BITS-1:0]);
        if (range_bad)
        begin
            status_calc = STATUS_OUT_OF_RANGE;
        end
        else if (ra_reg == rb_reg)
        begin
            status_calc = STATUS_SAME_RULE;
        end
        else if (filtered)
        begin
            status_calc = STATUS_FILTERED;
        end
        else
        begin
            status_calc = STATUS_COMPARED;
        end
        nh_sat = (11'(num_hashes_reg) > MAX_HASHES_W) ? MAX_HASHES_W[6:0] : num_hashes_reg;
    end

    // scan counter and match accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg     <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.scan_issue;
            if (cmd.check)
            begin
                m_reg     <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    m_reg <= m_reg + 7'd1;
                end
                if (pend_reg && (sig_a == sig_b))
                begin
                    count_reg <= count_reg + 7'd1;
                end
            end
        end
    end

    // status and signature length of the pair
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            status_reg <= status_calc;
            nh_reg     <= nh_sat;
        end
    end

    // output register, frees when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.match_count <= count_reg;
            rsp_reg.status      <= status_reg;
            rsp_reg.similar     <= (status_reg == STATUS_COMPARED) && (count_reg != 7'd0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    // status to controller
    always_comb
    begin
        stat.is_compare = is_compare;
        stat.early_done = (status_calc != STATUS_COMPARED) || (nh_sat == 7'd0);
        stat.scan_last  = ((m_reg + 7'd1) == nh_reg);
        stat.out_free   = !rsp_valid_reg || rsp_ready;
    end

    // checks
    `MHPS_ASSERT_HOLDS(a_scan_bound, clk, rst_n, cmd.scan_issue, m_reg < nh_reg,
        "signature read past the compared length")
    `MHPS_ASSERT_NEXT(a_scan_stop, clk, rst_n, cmd.scan_issue && stat.scan_last,
        !cmd.scan_issue, "scan continued after its last position")
    `MHPS_ASSERT_HOLDS(a_no_overwrite, clk, rst_n, cmd.out_load, !rsp_valid_reg || rsp_ready,
        "pending response overwritten")
    `MHPS_ASSERT_HOLDS(a_count_bound, clk, rst_n, cmd.out_load, count_reg <= nh_reg,
        "match count exceeds compared length")

endmodule

// ===== rtl/minhash_pair_similarity_top.sv =====
// Top level of the minhash pair similarity block.
// Depends on mhps_pkg, mhps_ctrl, mhps_datapath and mhps_ram.
//
// Usage:
//   req channel (req_valid/req_ready/req_item) takes load and compare beats.
//   A load beat writes one signature value plus the rule attributes; it
//   gives no response and passes through the load state before the next beat.
//   A compare beat names two rules and yields one rsp beat with the match
//   count and a status. A scanned compare goes through the attribute read,
//   check, scan (num_hashes positions, saturated to MAX_HASHES), drain and
//   done states; the scan reads both signatures through the two read ports
//   of the signature RAM, one position per cycle. Screened pairs (out of
//   range, same rule, filtered) and a zero num_hashes skip the scan and
//   drain states. The response register is loaded as the done state ends.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   index 0 is num_hashes, index 1 is num_rules. Write it only while idle.
//   Reset sets num_hashes to 64 and num_rules to 0; stores are not cleared.
//   A response waiting on a stalled receiver sits in an output register:
//   loads and a new compare are still accepted, and a compare only holds
//   in its last cycle until the previous response is taken.
module minhash_pair_similarity_top import mhps_pkg::*; #(
    parameter int MAX_RULES    = 256,
    parameter int MAX_HASHES   = 64,
    parameter int HEAD_ID_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_item_t  req_item,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_item_t  rsp_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data
);

    ctl_cmd_t   cmd;
    dp_status_t stat;

    // config writes are taken every cycle
    assign cfg_ready = 1'b1;

    // controller
    mhps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    mhps_datapath #(
        .MAX_RULES    (MAX_RULES),
        .MAX_HASHES   (MAX_HASHES),
        .HEAD_ID_BITS (HEAD_ID_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== dv/tb_minhash_pair_similarity_top.sv =====
// Self-checking testbench for minhash_pair_similarity_top: directed beats, then random phases.
// Depends on mhps_pkg and the block's RTL; predicts every response with its own signature model.
module tb_minhash_pair_similarity_top import mhps_pkg::*;;

    localparam int RULES     = 256;
    localparam int HASHES    = 64;
    localparam int SIG_DEPTH = RULES * HASHES;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req_item = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b1;
    rsp_item_t rsp_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_index = CFG_NUM_HASHES;
    logic [8:0] cfg_data = '0;

    minhash_pair_similarity_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // similarity scoreboard: mirrors the stores and queues predicted responses
    class similarity_scoreboard;
        logic [63:0] sig_mem [SIG_DEPTH];
        logic        kind_mem [RULES];
        logic [1:0]  type_mem [RULES];
        logic [23:0] head_mem [RULES];
        logic [6:0]  hash_len;
        logic [8:0]  rule_count;
        rsp_item_t   expected_q [$];
        int unsigned mismatches;

        function new();
            hash_len   = NUM_HASHES_RESET;
            rule_count = NUM_RULES_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [8:0] data);
            if (idx == CFG_NUM_HASHES)
                hash_len = data[6:0];
            else
                rule_count = data;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function rsp_item_t predict_compare(logic [7:0] a, logic [7:0] b);
            rsp_item_t   r;
            int unsigned nr;
            int unsigned nh;
            int unsigned hits;
            r    = '0;
            nr   = (rule_count > RULES) ? RULES : rule_count;
            nh   = (hash_len > HASHES) ? HASHES : hash_len;
            hits = 0;
            if (a >= nr || b >= nr)
            begin
                r.status = STATUS_OUT_OF_RANGE;
            end
            else if (a == b)
            begin
                r.status = STATUS_SAME_RULE;
            end
            else if (kind_mem[a] && kind_mem[b] && type_mem[a] == type_mem[b] &&
                     head_mem[a] != head_mem[b])
            begin
                r.status = STATUS_FILTERED;
            end
            else
            begin
                for (int m = 0; m < nh; m++)
                    if (sig_mem[a * HASHES + m] == sig_mem[b * HASHES + m])
                        hits++;
                if (hits > 127)
                    hits = 127;
                r.status      = STATUS_COMPARED;
                r.match_count = hits[6:0];
                r.similar     = (hits != 0);
            end
            return r;
        endfunction

        // accepted request beat: loads update the stores, compares queue a response
        function void note_input(req_item_t it);
            if (it.req_type == REQ_LOAD)
            begin
                sig_mem[it.rule_a * HASHES + it.position] = it.hash_value;
                kind_mem[it.rule_a] = it.is_constant_rule;
                type_mem[it.rule_a] = it.rule_type;
                head_mem[it.rule_a] = it.head_constant;
            end
            else
            begin
                expected_q.insert(expected_q.size(), predict_compare(it.rule_a, it.rule_b));
            end
        endfunction

        // accepted response beat against the oldest prediction
        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: count %0d status %0d similar %0d",
                             got.match_count, got.status, got.similar);
                return;
            end
            want = expected_q.pop_front();
            if (got.match_count !== want.match_count || got.status !== want.status ||
                got.similar !== want.similar)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"response mismatch: expected count %0d status %0d similar %0d,",
                              " got count %0d status %0d similar %0d"},
                             want.match_count, want.status, want.similar,
                             got.match_count, got.status, got.similar);
            end
        endfunction
    endclass

    similarity_scoreboard sb = new();

    // stimulus-side view of what has been written
    logic [63:0] shadow_sig [SIG_DEPTH];
    bit          sig_set [SIG_DEPTH];
    bit          attr_set [RULES];
    logic [6:0]  gen_hashes = NUM_HASHES_RESET;
    logic [8:0]  gen_rules = NUM_RULES_RESET;
    logic [63:0] value_pool [4];

    int unsigned items_done = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;

    always #1 clk = ~clk;

    // watchdog
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    // monitor: note accepted beats, check responses, randomize rsp_ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (req_valid && req_ready)
                sb.note_input(req_item);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp_item);
        end
        rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic int unsigned eff_hashes();
        return (gen_hashes > HASHES) ? HASHES : gen_hashes;
    endfunction

    function automatic int unsigned eff_rules();
        return (gen_rules > RULES) ? RULES : gen_rules;
    endfunction

    // a rule can be compared once its attributes and the scanned positions exist
    function automatic bit is_ready(int unsigned r);
        int unsigned nh;
        nh = eff_hashes();
        if (!attr_set[r])
            return 1'b0;
        for (int m = 0; m < nh; m++)
            if (!sig_set[r * HASHES + m])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return value_pool[$urandom_range(3)];
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [23:0] pick_head();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return 24'($urandom_range(3));
            default: return 24'($urandom);
        endcase
    endfunction

    // request beat with optional idle gap ahead; valid stays high after acceptance
    task automatic send_item(input req_item_t it);
        int unsigned gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do
            @(posedge clk);
        while (!req_ready);
        items_done++;
    endtask

    task automatic send_load(input int unsigned rule, input int unsigned pos,
                             input logic [63:0] value, input logic kind,
                             input logic [1:0] typ, input logic [23:0] head);
        req_item_t it;
        it.req_type         = REQ_LOAD;
        it.rule_a           = rule[7:0];
        it.rule_b           = 8'($urandom_range(255));
        it.position         = pos[5:0];
        it.hash_value       = value;
        it.is_constant_rule = kind;
        it.rule_type        = typ;
        it.head_constant    = head;
        shadow_sig[rule * HASHES + pos] = value;
        sig_set[rule * HASHES + pos]    = 1'b1;
        attr_set[rule]                  = 1'b1;
        send_item(it);
    endtask

    task automatic send_compare(input int unsigned a, input int unsigned b);
        req_item_t it;
        it.req_type         = REQ_COMPARE;
        it.rule_a           = a[7:0];
        it.rule_b           = b[7:0];
        it.position         = 6'($urandom_range(63));
        it.hash_value       = {$urandom, $urandom};
        it.is_constant_rule = 1'($urandom_range(1));
        it.rule_type        = 2'($urandom_range(3));
        it.head_constant    = 24'($urandom);
        send_item(it);
    endtask

    // hold the sender until every response is in, then let the block settle
    task automatic drain(input int unsigned settle);
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // both registers back to back, only while idle
    task automatic write_config(input logic [8:0] hashes_word, input logic [8:0] rules_word);
        drain(80);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NUM_HASHES;
        cfg_data  <= hashes_word;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_NUM_RULES;
        cfg_data  <= rules_word;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        gen_hashes = hashes_word[6:0];
        gen_rules  = rules_word;
    endtask

    // fill one rule's signature, partly copied from a partner; sometimes broken off
    task automatic load_sequence();
        int unsigned nh;
        int unsigned nr;
        int unsigned lim;
        int unsigned rule;
        int unsigned partner;
        int unsigned copy_pct;
        int unsigned count;
        int unsigned pos;
        bit          partial;
        logic        kind;
        logic [1:0]  typ;
        logic [23:0] head;
        logic [63:0] value;
        nh       = eff_hashes();
        nr       = eff_rules();
        lim      = (nr == 0) ? RULES : ((nr < 12) ? nr : 12);
        rule     = ($urandom_range(99) < 75) ? $urandom_range(lim - 1) : $urandom_range(255);
        partner  = $urandom_range(lim - 1);
        copy_pct = $urandom_range(100);
        partial  = ($urandom_range(99) < 20);
        kind     = 1'($urandom_range(1));
        typ      = 2'($urandom_range(3));
        head     = pick_head();
        count    = (nh == 0) ? 1 : nh;
        if (partial)
            count = $urandom_range(1, count);
        for (int m = 0; m < count; m++)
        begin
            pos = partial ? $urandom_range(63) : m;
            if ($urandom_range(99) < copy_pct && sig_set[partner * HASHES + pos])
                value = shadow_sig[partner * HASHES + pos];
            else
                value = pick_value();
            send_load(rule, pos, value, kind, typ, head);
        end
    endtask

    // compare two fully loaded rules in range, at times one with itself; else load a rule
    task automatic pair_compare();
        int unsigned rdy [$];
        int unsigned nr;
        int unsigned a;
        int unsigned b;
        nr = eff_rules();
        for (int r = 0; r < nr; r++)
            if (is_ready(r))
                rdy.insert(rdy.size(), r);
        if (rdy.size() == 0)
        begin
            load_sequence();
            return;
        end
        a = rdy[$urandom_range(rdy.size() - 1)];
        b = a;
        if (rdy.size() > 1 && $urandom_range(9) != 0)
            while (b == a)
                b = rdy[$urandom_range(rdy.size() - 1)];
        send_compare(a, b);
    endtask

    // any pair; a pair that would scan unwritten entries is made out of range or same-rule
    task automatic noise_compare();
        int unsigned nr;
        int unsigned a;
        int unsigned b;
        nr = eff_rules();
        a  = $urandom_range(255);
        b  = ($urandom_range(4) == 0) ? a : $urandom_range(255);
        if (a < nr && b < nr && a != b && !(is_ready(a) && is_ready(b)))
        begin
            if (nr < RULES)
                a = $urandom_range(RULES - 1, nr);
            else
                b = a;
        end
        send_compare(a, b);
    endtask

    initial
    begin
        int unsigned phase_hashes [8];
        int unsigned phase_rules [8];
        int unsigned phase_end;
        int unsigned half;
        int unsigned pick;
        logic [1:0]  spare;
        bit          paused;

        phase_hashes = '{3, 64, 1, 127, 0, 16, 7, 100};
        phase_rules  = '{8, 256, 2, 511, 5, 300, 1, 20};
        for (int k = 0; k < 4; k++)
            value_pool[k] = {$urandom, $urandom};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: out of range wins over same rule at reset settings
        send_compare(0, 0);
        write_config(9'h182, 9'd4);
        send_load(0, 0, '0, 1'b1, 2'd0, 24'h000000);
        send_load(0, 1, '1, 1'b1, 2'd0, 24'h000000);
        send_load(1, 0, '0, 1'b1, 2'd0, 24'hFFFFFF);
        send_load(1, 1, '1, 1'b1, 2'd0, 24'hFFFFFF);
        send_load(2, 0, '0, 1'b0, 2'd3, 24'h00007B);
        send_load(2, 1, 64'd5, 1'b0, 2'd3, 24'h00007B);
        send_load(3, 0, '1, 1'b1, 2'd0, 24'h000000);
        send_load(3, 1, '1, 1'b1, 2'd0, 24'h000000);
        send_load(255, 63, {$urandom, $urandom}, 1'b1, 2'd2, 24'hFFFFFF);
        // filtered, partial matches, no match, same rule, out of range
        send_compare(0, 1);
        send_compare(0, 2);
        send_compare(0, 3);
        send_compare(1, 2);
        send_compare(2, 3);
        send_compare(1, 1);
        send_compare(4, 0);
        send_compare(0, 255);
        // zero signature length, full rule range
        write_config(9'd0, 9'd256);
        send_compare(0, 2);
        send_compare(0, 1);
        send_compare(255, 255);
        send_compare(0, 255);

        // random phases over several settings and idling modes
        for (int ph = 0; ph < 8; ph++)
        begin
            spare = 2'($urandom_range(3));
            write_config(9'(phase_hashes[ph]) | {spare, 7'd0}, 9'(phase_rules[ph]));
            case (ph % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 67;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 67;
                end
                default:
                begin
                    tx_idle_pct  = 9;
                    rx_stall_pct = 9;
                end
            endcase
            phase_end = items_done + 216;
            half      = items_done + 108;
            paused    = 1'b0;
            while (items_done < phase_end)
            begin
                if (!paused && items_done >= half)
                begin
                    drain(0);
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 10)
                    noise_compare();
                else if (pick < 35)
                    load_sequence();
                else
                    pair_compare();
            end
        end

        // wind down
        drain(100);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
